// ----- design/bmc1d_pkg.sv -----
// Package for the 1-D border-mode convolution core: constants, codes, types.
`default_nettype none
package bmc1d_pkg;
	localparam int MaxTaps   = 31;
	localparam int MaxLength = 1024;
	localparam int TapAw     = $clog2(MaxTaps);
	localparam int SampAw    = $clog2(MaxLength);
	localparam int HalfMax   = (MaxTaps - 1) / 2;
	localparam int AccW      = 48;
	localparam int WsumW     = 24;

	typedef enum logic [1:0] {
		OP_TAP  = 2'd0,
		OP_SAMP = 2'd1,
		OP_COMP = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		BM_ZERO  = 3'd0,
		BM_RENORM = 3'd1,
		BM_CONST = 3'd2,
		BM_REPL  = 3'd3,
		BM_REFL  = 3'd4,
		BM_REFL101 = 3'd5,
		BM_WRAP  = 3'd6,
		BM_SPARE = 3'd7
	} bmode_t;

	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_HALF  = 2'd1,
		REG_LEN   = 2'd2,
		REG_CONST = 2'd3
	} regidx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_FOLD,
		ST_READ,
		ST_MAC,
		ST_DIV,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- design/bmc1d_div.sv -----
// Restoring divider for the renormalised mode: one quotient bit per cycle.
`default_nettype none
module bmc1d_div import bmc1d_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [AccW:0]        num,
	input  wire logic [WsumW:0]       den,
	output logic                      busy,
	output logic                      done,
	output logic [AccW:0]             quo
);
	localparam int CntW = $clog2(AccW + 2);
	logic [CntW-1:0] cnt_q;
	logic [AccW:0]   quo_q;
	logic [WsumW+1:0] rem_q;
	logic [WsumW:0]  den_q;
	logic            busy_q;
	logic            done_q;
	logic [WsumW+1:0] shifted;
	logic [WsumW+1:0] diff;

	assign shifted = {rem_q[WsumW:0], quo_q[AccW]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(AccW + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[WsumW+1]) begin
				rem_q <= diff;
				quo_q <= {quo_q[AccW-1:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[AccW-1:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ----- design/border_mode_convolution_1d_core.sv -----
// Top level of the 1-D convolution core with border extrapolation.
// Usage:
//  Configure border_mode, kernel_half, signal_length and constant_value through
//  the write port (cfg_we, cfg_index, cfg_data) while the core is idle.
//  Issue a beat with start high while busy is low. Opcode 0 writes a tap,
//  opcode 1 writes a sample; neither raises busy, so one write fits each cycle.
//  Opcode 2 computes one output position: a MOD step sets up the start residue
//  of the fold, adding one period per step while it is negative in a folding
//  mode; then per tap a fold step, a memory read step and a MAC step through
//  the shared multiplier, then a finish step and a done step. In renormalized
//  mode, when the tap sum is nonzero, the finish step waits for the serial
//  divider. Busy stays high from the accepted beat until the done step ends.
//  The result shows on the result ports for one cycle with result_valid high,
//  in the first cycle in which busy is low; a new beat may be accepted then.
//  The receiver cannot stall, so it must take it in that cycle.
//  Reset clears the registers to mode 0, half 0, length 1, constant 0, and
//  the sequencer to idle. The tap and sample stores are not cleared.
`default_nettype none
module border_mode_convolution_1d_core import bmc1d_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [9:0]         position,
	input  wire logic signed [15:0] value,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    result_valid,
	output logic [9:0]              result_position,
	output logic signed [23:0]      result_value,
	output logic                    saturated,
	output logic                    zero_weight
);
	localparam int LenW = SampAw + 1;
	localparam int PW   = SampAw + 3;  // signed position width

	// Configuration registers
	logic [2:0]  mode_q;
	logic [3:0]  half_q;
	logic [10:0] len_q;
	logic [15:0] const_q;

	// Stores
	logic [15:0] tap_mem [MaxTaps];
	logic [15:0] samp_mem [MaxLength];
	logic [15:0] tap_rd_q;
	logic [15:0] samp_rd_q;

	state_t state_q, state_d;
	logic [TapAw-1:0]   k_q;
	logic [TapAw-1:0]   taps_m1_q;
	logic signed [PW-1:0] p_q;      // raw position of current tap
	logic signed [PW-1:0] v_q;      // start residue while it is folded up
	logic [LenW:0]      m_q;        // p mod period, kept incrementally
	logic [LenW-1:0]    elen_q;
	bmode_t             emode_q;
	logic [9:0]         pos_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [WsumW-1:0] wsum_q;
	logic [SampAw-1:0]  idx_q;
	logic               use_s2;     // tap contributes to the sum
	logic               use_q, inr_q, cst_q;

	// Effective parameters of the current compute
	logic [LenW-1:0] elen;
	logic [3:0]      ehalf;
	bmode_t          emode;
	logic [LenW:0]   period;
	always_comb begin
		elen = len_q;
		if (len_q == '0) elen = LenW'(1);
		if (len_q > LenW'(MaxLength)) elen = LenW'(MaxLength);
		ehalf = (half_q > 4'(HalfMax)) ? 4'(HalfMax) : half_q;
		emode = (mode_q == BM_SPARE) ? BM_ZERO : bmode_t'(mode_q);
	end
	always_comb begin
		unique case (emode_q)
			BM_REFL:    period = {elen_q, 1'b0};
			BM_REFL101: period = {elen_q, 1'b0} - (LenW+1)'(2);
			default:    period = {1'b0, elen_q};
		endcase
	end

	// Add one period per cycle until the start residue is no longer negative
	logic fold_md;
	logic mod_step;
	assign fold_md = (emode_q == BM_REFL) || (emode_q == BM_REFL101)
		|| (emode_q == BM_WRAP);
	assign mod_step = v_q[PW-1] && fold_md && (period != '0);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			half_q  <= '0;
			len_q   <= 11'd1;
			const_q <= '0;
		end else if (cfg_we) begin
			unique case (regidx_t'(cfg_index))
				REG_MODE:  mode_q  <= cfg_data[2:0];
				REG_HALF:  half_q  <= cfg_data[3:0];
				REG_LEN:   len_q   <= cfg_data[10:0];
				REG_CONST: const_q <= cfg_data;
			endcase
		end
	end

	wire accept = start && !busy;
	wire go_comp = accept && opcode_t'(opcode) == OP_COMP
		&& {1'b0, position} < elen;

	// Store writes and registered reads
	always_ff @(posedge clk) begin
		if (accept && opcode_t'(opcode) == OP_TAP && position < 10'(MaxTaps))
			tap_mem[position[TapAw-1:0]] <= value;
		if (accept && opcode_t'(opcode) == OP_SAMP)
			samp_mem[position[SampAw-1:0]] <= value;
		if (state_q == ST_READ) begin
			tap_rd_q  <= tap_mem[k_q];
			samp_rd_q <= samp_mem[idx_q];
		end
	end

	// Fold of current position into sample index
	logic inr;
	logic [SampAw-1:0] fidx;
	logic [LenW:0] mirror;
	always_comb begin
		inr = (p_q >= 0) && (p_q < $signed({2'b0, elen_q}));
		mirror = (emode_q == BM_REFL) ? period - (LenW+1)'(1) - m_q
			: period - m_q;
		fidx = p_q[SampAw-1:0];
		if (!inr) begin
			unique case (emode_q)
				BM_REPL: fidx = (p_q < 0) ? '0 : SampAw'(elen_q - 1'b1);
				BM_WRAP: fidx = m_q[SampAw-1:0];
				BM_REFL, BM_REFL101: begin
					if (elen_q == LenW'(1)) fidx = '0;
					else if (m_q < {1'b0, elen_q}) fidx = m_q[SampAw-1:0];
					else fidx = mirror[SampAw-1:0];
				end
				default: fidx = '0;
			endcase
		end
	end
	assign use_s2 = inr || (emode_q != BM_ZERO && emode_q != BM_RENORM);

	// Shared multiply-accumulate
	logic signed [15:0] s_op;
	logic signed [31:0] prod;
	assign s_op = cst_q ? $signed(const_q) : $signed(samp_rd_q);
	assign prod = s_op * $signed(tap_rd_q);

	// Divider for renormalized mode
	logic           div_go;
	logic           div_busy;
	logic           div_done;
	logic [AccW:0]  dnum;
	logic [WsumW:0] dden;
	logic [AccW:0]  dquo;
	logic [AccW:0]  aabs;
	logic [WsumW:0] wabs;
	assign aabs = acc_q[AccW-1] ? (AccW+1)'(-acc_q) : (AccW+1)'(acc_q);
	assign wabs = wsum_q[WsumW-1] ? (WsumW+1)'(-wsum_q) : (WsumW+1)'(wsum_q);
	assign dnum = {aabs[AccW-1:0], 1'b0} + (AccW+1)'(wabs);
	assign dden = {wabs[WsumW-1:0], 1'b0};
	bmc1d_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(dnum), .den(dden),
		.busy(div_busy), .done(div_done), .quo(dquo)
	);

	// Sequencer: MOD once, FOLD -> READ -> MAC per tap, then DIV and DONE
	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: if (go_comp) state_d = ST_MOD;
			ST_MOD: if (!mod_step) state_d = ST_FOLD;
			ST_FOLD: state_d = ST_READ;
			ST_READ: state_d = ST_MAC;
			ST_MAC: begin
				if (k_q != taps_m1_q) state_d = ST_FOLD;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (emode_q != BM_RENORM || wsum_q == '0) state_d = ST_DONE;
				else if (div_done) state_d = ST_DONE;
				else if (!div_busy) div_go = 1'b1;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath: setup at accept, residue fold, then per tap advance the position and its running modulo
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (go_comp) begin
				pos_q     <= position;
				elen_q    <= elen;
				emode_q   <= emode;
				taps_m1_q <= TapAw'({ehalf, 1'b0});
				k_q       <= '0;
				p_q       <= $signed({3'b0, position}) - $signed(PW'(ehalf));
				v_q       <= $signed({3'b0, position}) - $signed(PW'(ehalf));
				acc_q     <= '0;
				wsum_q    <= '0;
			end
			ST_MOD: begin
				if (mod_step) v_q <= v_q + $signed({1'b0, period});
				else m_q <= v_q[LenW:0];
			end
			ST_FOLD: begin
				idx_q <= fidx;
				use_q <= use_s2;
				inr_q <= inr;
				cst_q <= !inr && emode_q == BM_CONST;
			end
			ST_MAC: begin
				if (use_q) acc_q <= acc_q + AccW'(prod);
				if (inr_q) wsum_q <= wsum_q + WsumW'($signed(tap_rd_q));
				k_q <= k_q + 1'b1;
				p_q <= p_q + PW'(1);
				m_q <= (m_q + 1'b1 >= period) ? '0 : m_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Result formatting and saturation
	logic signed [AccW:0] rnd;
	logic signed [AccW:0] res;
	logic [AccW:0]        q;
	logic                 sat, zw;
	logic signed [23:0]   rv;
	always_comb begin
		rnd = ($signed({acc_q[AccW-1], acc_q}) + (AccW+1)'(16384)) >>> 15;
		q   = (dquo > (AccW+1)'(8388608)) ? (AccW+1)'(8388608) : dquo;
		zw  = 1'b0;
		if (emode_q == BM_RENORM) begin
			if (wsum_q == '0) begin
				res = '0;
				zw  = 1'b1;
			end else begin
				res = (acc_q[AccW-1] ^ wsum_q[WsumW-1]) ? -$signed(q) : $signed(q);
			end
		end else begin
			res = rnd;
		end
		sat = 1'b0;
		rv  = res[23:0];
		if (res > $signed((AccW+1)'(8388607))) begin
			rv = 24'sh7FFFFF; sat = 1'b1;
		end else if (res < -$signed((AccW+1)'(8388608))) begin
			rv = 24'sh800000; sat = 1'b1;
		end
	end

	// Hold the result for one beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= (state_q == ST_DONE);
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			result_position <= pos_q;
			result_value    <= rv;
			saturated       <= sat;
			zero_weight     <= zw;
		end
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// ----- tb/sv/border_mode_convolution_1d_checker.sv -----
// Checker for the 1-D convolution core: predicts each compute result and compares it.
`timescale 1ns / 1ps
module border_mode_convolution_1d_checker import bmc1d_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [9:0]         position,
	input  wire logic signed [15:0] value,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               result_valid,
	input  wire logic [9:0]         result_position,
	input  wire logic signed [23:0] result_value,
	input  wire logic               saturated,
	input  wire logic               zero_weight,
	output int                      fails,
	output int                      pending
);
	localparam int ExpDepth = 4;

	typedef struct {
		logic [9:0]         pos;
		logic signed [23:0] val;
		logic               sat;
		logic               zw;
	} conv_out_t;

	logic [2:0]         mode_reg;
	logic [3:0]         half_reg;
	logic [10:0]        len_reg;
	logic signed [15:0] fill_reg;
	logic signed [15:0] taps [MaxTaps];
	logic signed [15:0] samples [MaxLength];
	conv_out_t          expected_outs [ExpDepth];
	int                 wr_cnt;
	int                 rd_cnt;

	function automatic longint wrap_mod(longint a, longint m);
		longint r;
		r = a % m;
		return (r < 0) ? r + m : r;
	endfunction

	function automatic longint border_index(longint p, longint len, bmode_t md);
		longint m;
		if (md == BM_REPL)
			return (p < 0) ? 0 : len - 1;
		if (md == BM_WRAP)
			return wrap_mod(p, len);
		if (len == 1)
			return 0;
		if (md == BM_REFL) begin
			m = wrap_mod(p, 2 * len);
			return (m < len) ? m : 2 * len - 1 - m;
		end
		m = wrap_mod(p, 2 * len - 2);
		return (m < len) ? m : 2 * len - 2 - m;
	endfunction

	// Walk all taps for one output position and round/saturate as the core does.
	function automatic conv_out_t convolve_at(logic [9:0] pos);
		conv_out_t o;
		bmode_t    md;
		longint    len, p, s, acc, wsum, res, num, den, q;
		bit        neg;
		md = bmode_t'((mode_reg == BM_SPARE) ? BM_ZERO : mode_reg);
		len = (len_reg == 0) ? 1 : ((len_reg > MaxLength) ? MaxLength : len_reg);
		acc = 0;
		wsum = 0;
		o.pos = pos;
		o.sat = 0;
		o.zw = 0;
		for (int k = 0; k < 2 * half_reg + 1; k++) begin
			p = longint'(pos) - half_reg + k;
			if (p >= 0 && p < len) begin
				s = samples[p];
				wsum += taps[k];
			end else if (md == BM_ZERO || md == BM_RENORM) begin
				continue;
			end else if (md == BM_CONST) begin
				s = fill_reg;
			end else begin
				s = samples[border_index(p, len, md)];
			end
			acc += s * taps[k];
		end
		if (md == BM_RENORM) begin
			if (wsum == 0) begin
				res = 0;
				o.zw = 1;
			end else begin
				neg = (acc < 0) != (wsum < 0);
				num = (acc < 0) ? -acc : acc;
				den = (wsum < 0) ? -wsum : wsum;
				q = (2 * num + den) / (2 * den);
				if (q > 8388608) q = 8388608;
				res = neg ? -q : q;
			end
		end else begin
			res = (acc + 16384) >>> 15;
		end
		if (res > 8388607) begin
			res = 8388607;
			o.sat = 1;
		end
		if (res < -8388608) begin
			res = -8388608;
			o.sat = 1;
		end
		o.val = res[23:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("t=%0t %s: got %0d, want %0d", $time, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
		wr_cnt = 0;
		rd_cnt = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		conv_out_t w;
		longint    eff_len;
		if (!arst_n) begin
			mode_reg <= BM_ZERO;
			half_reg <= '0;
			len_reg <= 11'd1;
			fill_reg <= '0;
		end else begin
			if (result_valid) begin
				if (wr_cnt == rd_cnt) begin
					report_mismatch("unexpected result at position", result_position, -1);
				end else begin
					w = expected_outs[rd_cnt % ExpDepth];
					rd_cnt++;
					if (result_position !== w.pos)
						report_mismatch("result_position", result_position, w.pos);
					if (result_value !== w.val)
						report_mismatch("result_value", result_value, w.val);
					if (saturated !== w.sat)
						report_mismatch("saturated", saturated, w.sat);
					if (zero_weight !== w.zw)
						report_mismatch("zero_weight", zero_weight, w.zw);
				end
			end
			if (start && !busy) begin
				case (opcode_t'(opcode))
					OP_TAP: if (position < MaxTaps) taps[position] = value;
					OP_SAMP: samples[position] = value;
					OP_COMP: begin
						eff_len = (len_reg == 0) ? 1 :
							((len_reg > MaxLength) ? MaxLength : len_reg);
						if (position < eff_len) begin
							if (wr_cnt - rd_cnt >= ExpDepth) begin
								report_mismatch("results outstanding", wr_cnt - rd_cnt,
									ExpDepth - 1);
							end else begin
								expected_outs[wr_cnt % ExpDepth] = convolve_at(position);
								wr_cnt++;
							end
						end
					end
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (regidx_t'(cfg_index))
					REG_MODE: mode_reg <= cfg_data[2:0];
					REG_HALF: half_reg <= cfg_data[3:0];
					REG_LEN: len_reg <= cfg_data[10:0];
					REG_CONST: fill_reg <= cfg_data;
				endcase
			end
			pending = wr_cnt - rd_cnt;
		end
	end
endmodule

// ----- tb/sv/border_mode_convolution_1d_core_test.sv -----
// Top of the testbench for the 1-D convolution core: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps
module border_mode_convolution_1d_core_test;
	import bmc1d_pkg::*;

	// Extra clocks waited in drain() after the last expected result has landed.
	localparam int DrainCycles = 200;
	localparam int CycleLimit  = 1_000_000;
	localparam int EndFill     = 64;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [1:0]         opcode = OP_NONE;
	logic [9:0]         position = '0;
	logic signed [15:0] value = '0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = REG_MODE;
	logic [15:0]        cfg_data = '0;
	logic               result_valid;
	logic [9:0]         result_position;
	logic signed [23:0] result_value;
	logic               saturated;
	logic               zero_weight;
	int                 fails;
	int                 pending;
	int                 cycles = 0;

	// Shadow of what was programmed, used only to steer compute positions.
	int                 cur_half = 0;
	int                 cur_len = 1;
	bit                 no_gaps = 0;

	always #5 clk = ~clk;

	border_mode_convolution_1d_core dut (.*);

	border_mode_convolution_1d_checker checker_i (.*);

	// Hard stop in case the core hangs or drops a handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Issue one beat. Keep start high across back-to-back beats; drop it only for a gap.
	task automatic send_beat(opcode_t op, int pos, logic [15:0] val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		opcode <= op;
		position <= pos[9:0];
		value <= val;
		do @(posedge clk); while (busy);
	endtask

	// Let all outstanding computes land, then give the core time to go idle.
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(regidx_t idx, logic [15:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_core(bmode_t md, int half, int len, logic [15:0] fill);
		drain();
		write_reg(REG_MODE, {13'b0, md});
		write_reg(REG_HALF, half[15:0]);
		write_reg(REG_LEN, len[15:0]);
		write_reg(REG_CONST, fill);
		cfg_we <= 0;
		cur_half = half;
		cur_len = (len == 0) ? 1 : ((len > MaxLength) ? MaxLength : len);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Favor positions whose tap window crosses a border. Long signals stay near
	// their ends, where the sample store was filled.
	function automatic int rand_compute_pos();
		int r, edge_w;
		r = $urandom_range(0, 9);
		edge_w = (cur_half < cur_len - 1) ? cur_half : cur_len - 1;
		if (r < 4) return $urandom_range(0, edge_w);
		if (r < 8) return cur_len - 1 - $urandom_range(0, edge_w);
		if (cur_len > EndFill)
			return (r < 9) ? $urandom_range(0, 31) : cur_len - 1 - $urandom_range(0, 31);
		if (r < 9) return $urandom_range(0, cur_len - 1);
		return $urandom_range(0, 1023);
	endfunction

	task automatic random_beat();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) send_beat(OP_TAP, $urandom_range(0, 40), rand_value());
		else if (r < 35) send_beat(OP_SAMP, $urandom_range(0, 1023), rand_value());
		else if (r < 95) send_beat(OP_COMP, rand_compute_pos(), 16'($urandom()));
		else send_beat(OP_NONE, $urandom_range(0, 1023), 16'($urandom()));
	endtask

	initial begin
		int lens [7] = '{1, 2, 3, 1024, 0, 2047, 17};
		int half, len;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill all taps and both ends of the sample store back to back; computes
		// only reach into those entries.
		no_gaps = 1;
		for (int i = 0; i < MaxTaps; i++) send_beat(OP_TAP, i, rand_value());
		for (int i = 0; i < EndFill; i++) send_beat(OP_SAMP, i, rand_value());
		for (int i = MaxLength - EndFill; i < MaxLength; i++)
			send_beat(OP_SAMP, i, rand_value());
		no_gaps = 0;

		// Reset config: single tap, length one; compute past the end gives nothing.
		send_beat(OP_COMP, 0, 16'h0);
		send_beat(OP_COMP, 5, 16'h0);
		send_beat(OP_NONE, 3, 16'h1234);
		send_beat(OP_TAP, 40, 16'h5555);

		// Renormalized mode: taps summing to zero, then a nonzero tap sum with extreme samples.
		program_core(BM_RENORM, 1, 100, 16'h0);
		send_beat(OP_TAP, 0, 16'h4000);
		send_beat(OP_TAP, 1, 16'h0000);
		send_beat(OP_TAP, 2, 16'hC000);
		send_beat(OP_COMP, 50, 16'h0);
		send_beat(OP_TAP, 0, 16'h7FFF);
		send_beat(OP_TAP, 1, 16'h8002);
		send_beat(OP_SAMP, 49, 16'h7FFF);
		send_beat(OP_SAMP, 50, 16'h8000);
		send_beat(OP_COMP, 50, 16'h0);

		// Every border mode on a single-sample signal with the widest kernel.
		for (int m = BM_ZERO; m <= BM_SPARE; m++) begin
			program_core(bmode_t'(m), 15, 1, 16'h8000);
			send_beat(OP_COMP, 0, 16'h0);
		end

		// Random phases: walk all modes, extreme and small sizes.
		for (int ph = 0; ph < 14; ph++) begin
			half = (ph % 3 == 0) ? 15 : ((ph % 3 == 1) ? 0 : $urandom_range(0, 15));
			len = (ph < 7) ? lens[ph] : $urandom_range(1, 40);
			program_core(bmode_t'(ph % 8), half, len, rand_value());
			no_gaps = (ph % 4 == 3);
			repeat (37) random_beat();
			no_gaps = 0;
		end

		drain();
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
